/* rtl/gpr_pkg.sv */
// Shared types, constants and helpers for the galvo position ramp.
// No dependencies; every other file imports this package.
package gpr_pkg;

   localparam int DAC_BITS      = 18;
   localparam int FRACTION_BITS = 10;
   localparam int DIST_W        = DAC_BITS + FRACTION_BITS;
   localparam int POS_W         = DAC_BITS + 1;
   localparam int SUM_W         = DAC_BITS + 2;
   localparam int CFG_W         = 16;
   localparam int DIV_W         = (DIST_W > CFG_W) ? DIST_W : CFG_W;
   localparam int CODE_W        = 4;
   localparam int FRAME_W       = 24;
   localparam int CMD_W         = 2;
   localparam int DIR_W         = 2;
   localparam int DSEL_W        = 2;
   localparam int ADDR_W        = 5;
   localparam int REG_IDX_W     = 3;
   localparam int DATA_W        = 32;

   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ABS  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REL  = 2'd2;

   localparam logic [DIR_W-1:0] DIR_DEC  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_INC  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_JUMP = 2'd2;

   localparam logic [DSEL_W-1:0] DSEL_SPEED  = 2'd0;
   localparam logic [DSEL_W-1:0] DSEL_PERIOD = 2'd1;
   localparam logic [DSEL_W-1:0] DSEL_STEP   = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_SPEED  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CENTER = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MIN    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CODE   = 3'd5;

   localparam logic [CFG_W-1:0]    SPEED_RESET  = 16'd1024;
   localparam logic [CFG_W-1:0]    PERIOD_RESET = 16'd10;
   localparam logic [DAC_BITS-1:0] CENTER_RESET = DAC_BITS'(131072);
   localparam logic [DAC_BITS-1:0] DMIN_RESET   = '0;
   localparam logic [DAC_BITS-1:0] DAC_FULL     = '1;
   localparam logic [CODE_W-1:0]   CODE_RESET   = 4'd1;

   localparam logic [7:0] BYTE_MASK = 8'hFF;
   localparam int HI_SHIFT  = 14;
   localparam int MID_SHIFT = 6;
   localparam int LO_SHIFT  = 2;

   typedef struct packed {
      logic [CFG_W-1:0]    speed;
      logic [CFG_W-1:0]    period;
      logic [DAC_BITS-1:0] center;
      logic [DAC_BITS-1:0] dac_min;
      logic [DAC_BITS-1:0] dac_max;
      logic [CODE_W-1:0]   write_code;
   } cfg_type;

   typedef struct packed {
      logic              load_item;
      logic              load_tgt;
      logic              load_dist;
      logic              div_start;
      logic [DSEL_W-1:0] div_sel;
      logic              cap_step;
      logic              commit;
      logic              load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_move;
      logic need_move;
      logic speed_zero;
      logic div_done;
      logic out_free;
   } dp_status_type;

   // DAC write frame: command nibble over the code bytes
   function automatic logic [FRAME_W-1:0] frame_of(input logic [DAC_BITS-1:0] cur,
                                                   input logic [CODE_W-1:0] code);
      logic [31:0] c;
      logic [7:0]  b2;
      logic [7:0]  b1;
      logic [7:0]  b0;
      c  = 32'(cur);
      b2 = 8'((32'(code) << 4) | (c >> HI_SHIFT)) & BYTE_MASK;
      b1 = 8'(c >> MID_SHIFT);
      b0 = 8'(c << LO_SHIFT);
      return {b2, b1, b0};
   endfunction

endpackage

/* rtl/gpr_csr.sv */
// Configuration register file behind the APB-style port.
// Depends on gpr_pkg.
module gpr_csr import gpr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [REG_IDX_W-1:0]   idx;
   logic                   wr;

   assign idx    = paddr[ADDR_W-1:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_SPEED:  cfg_in.speed      = pwdata[CFG_W-1:0];
            REG_PERIOD: cfg_in.period     = pwdata[CFG_W-1:0];
            REG_CENTER: cfg_in.center     = pwdata[DAC_BITS-1:0];
            REG_MIN:    cfg_in.dac_min    = pwdata[DAC_BITS-1:0];
            REG_MAX:    cfg_in.dac_max    = pwdata[DAC_BITS-1:0];
            REG_CODE:   cfg_in.write_code = pwdata[CODE_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SPEED:  prdata = DATA_W'(cfg_ff.speed);
         REG_PERIOD: prdata = DATA_W'(cfg_ff.period);
         REG_CENTER: prdata = DATA_W'(cfg_ff.center);
         REG_MIN:    prdata = DATA_W'(cfg_ff.dac_min);
         REG_MAX:    prdata = DATA_W'(cfg_ff.dac_max);
         REG_CODE:   prdata = DATA_W'(cfg_ff.write_code);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed      <= SPEED_RESET;
         cfg_ff.period     <= PERIOD_RESET;
         cfg_ff.center     <= CENTER_RESET;
         cfg_ff.dac_min    <= DMIN_RESET;
         cfg_ff.dac_max    <= DAC_FULL;
         cfg_ff.write_code <= CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/gpr_div.sv */
// Restoring divider, one quotient bit per cycle; done rises once the last quotient bit is in.
// Depends on gpr_pkg.
module gpr_div import gpr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   trial;

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign shifted  = {rem_ff, quo_ff[DIV_W-1]};
   assign trial    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial[DIV_W]) begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

/* rtl/gpr_dp.sv */
// Datapath: item latch, target clamp, step computation, ramp state, result register.
// Depends on gpr_pkg and gpr_div.
module gpr_dp import gpr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  ctrl_cmd_type               cmd,
   output dp_status_type              status,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [POS_W-1:0]    req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DAC_BITS-1:0]        rsp_dac_value,
   output logic [FRAME_W-1:0]         rsp_spi_frame,
   output logic                       rsp_at_target,
   output logic [DIR_W-1:0]           rsp_direction
);

   logic [CMD_W-1:0]        cmd_ff;
   logic signed [POS_W-1:0] pos_ff;
   logic [DAC_BITS-1:0]     tgt_new_ff, tgt_new_in;
   logic [DIV_W-1:0]        dist_ff, dist_in;
   logic [DIST_W-1:0]       step_new_ff;
   logic [DAC_BITS-1:0]     cur_ff, tick_next;
   logic [DAC_BITS-1:0]     target_ff;
   logic [DIST_W-1:0]       step_ff;
   logic [DIR_W-1:0]        dir_ff;
   logic                    rsp_valid_ff;
   logic [DAC_BITS-1:0]     rsp_dac_ff;
   logic [FRAME_W-1:0]      rsp_frame_ff;
   logic                    rsp_at_ff;
   logic [DIR_W-1:0]        rsp_dir_ff;

   logic signed [SUM_W-1:0] pos_ext, base_ext, sum, max_ext, min_ext, t1;
   logic [DAC_BITS-1:0]     base, d;
   logic                    is_move, need_move;
   logic [DIV_W-1:0]        dvd, dvs, quo;
   logic                    div_done;
   logic [DIST_W:0]         inc_sum;
   logic [DAC_BITS-1:0]     dec_val;

   assign is_move   = (cmd_ff == CMD_ABS) || (cmd_ff == CMD_REL);
   assign need_move = cur_ff != tgt_new_ff;

   assign status.is_move    = is_move;
   assign status.need_move  = need_move;
   assign status.speed_zero = cfg.speed == '0;
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // new target, clamped against the limits then the code range
   always_comb begin
      base     = (cmd_ff == CMD_ABS) ? cfg.center : cur_ff;
      pos_ext  = SUM_W'(pos_ff);
      base_ext = signed'({2'b00, base});
      max_ext  = signed'({2'b00, cfg.dac_max});
      min_ext  = signed'({2'b00, cfg.dac_min});
      sum      = pos_ext + base_ext;
      if (sum > max_ext) begin
         t1 = max_ext;
      end else if (sum < min_ext) begin
         t1 = min_ext;
      end else begin
         t1 = sum;
      end
      if (t1 < 0) begin
         tgt_new_in = '0;
      end else if (t1 > signed'({2'b00, DAC_FULL})) begin
         tgt_new_in = DAC_FULL;
      end else begin
         tgt_new_in = DAC_BITS'(t1);
      end
   end

   always_comb begin
      d       = (cur_ff > tgt_new_ff) ? (cur_ff - tgt_new_ff) : (tgt_new_ff - cur_ff);
      dist_in = DIV_W'(d) << FRACTION_BITS;
   end

   // the first divide starts in the cycle that loads the distance
   always_comb begin
      case (cmd.div_sel)
         DSEL_SPEED: begin
            dvd = dist_in;
            dvs = DIV_W'(cfg.speed);
         end
         DSEL_PERIOD: begin
            dvd = quo;
            dvs = (cfg.period == '0) ? DIV_W'(1) : DIV_W'(cfg.period);
         end
         DSEL_STEP: begin
            dvd = dist_ff;
            dvs = (quo == '0) ? DIV_W'(1) : quo;
         end
         default: begin
            dvd = dist_ff;
            dvs = DIV_W'(1);
         end
      endcase
   end

   gpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );

   // one tick of the ramp
   always_comb begin
      inc_sum = (DIST_W+1)'(cur_ff) + (DIST_W+1)'(step_ff);
      dec_val = (step_ff >= DIST_W'(cur_ff)) ? '0 : (cur_ff - DAC_BITS'(step_ff));
      case (dir_ff)
         DIR_DEC:  tick_next = (dec_val < target_ff) ? target_ff : dec_val;
         DIR_INC:  tick_next = (inc_sum > (DIST_W+1)'(target_ff)) ? target_ff
                                                                  : DAC_BITS'(inc_sum);
         DIR_JUMP: tick_next = target_ff;
         default:  tick_next = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         cmd_ff <= req_command;
         pos_ff <= req_position;
      end
      if (cmd.load_tgt) begin
         tgt_new_ff <= tgt_new_in;
      end
      if (cmd.load_dist) begin
         dist_ff     <= dist_in;
         step_new_ff <= '0;
      end else if (cmd.cap_step) begin
         step_new_ff <= DIST_W'(quo);
      end
      if (cmd.load_out) begin
         rsp_dac_ff   <= cur_ff;
         rsp_frame_ff <= (cmd_ff == CMD_TICK) ? frame_of(cur_ff, cfg.write_code) : '0;
         rsp_at_ff    <= cur_ff == target_ff;
         rsp_dir_ff   <= dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         target_ff    <= CENTER_RESET;
         step_ff      <= '0;
         dir_ff       <= DIR_JUMP;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            if (cmd_ff == CMD_TICK) begin
               cur_ff <= tick_next;
            end else if (is_move) begin
               target_ff <= tgt_new_ff;
               if (need_move) begin
                  dir_ff  <= (cur_ff < tgt_new_ff) ? DIR_INC : DIR_DEC;
                  step_ff <= step_new_ff;
               end
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dac_value = rsp_dac_ff;
   assign rsp_spi_frame = rsp_frame_ff;
   assign rsp_at_target = rsp_at_ff;
   assign rsp_direction = rsp_dir_ff;

endmodule

/* rtl/gpr_ctrl.sv */
// Controller state machine: sequences target clamp, three divides, commit and result.
// Depends on gpr_pkg.
module gpr_ctrl import gpr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TGT    = 3'd1;
   localparam logic [2:0] S_DIST   = 3'd2;
   localparam logic [2:0] S_DIV1   = 3'd3;
   localparam logic [2:0] S_DIV2   = 3'd4;
   localparam logic [2:0] S_DIV3   = 3'd5;
   localparam logic [2:0] S_COMMIT = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_TGT;
            end
         end
         S_TGT: begin
            if (status.is_move) begin
               cmd.load_tgt = 1'b1;
               state_in     = S_DIST;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIST: begin
            cmd.load_dist = 1'b1;
            if (status.need_move && !status.speed_zero) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_SPEED;
               state_in      = S_DIV1;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIV1: begin
            cmd.div_sel = DSEL_PERIOD;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV2;
            end
         end
         S_DIV2: begin
            cmd.div_sel = DSEL_STEP;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV3;
            end
         end
         S_DIV3: begin
            if (status.div_done) begin
               cmd.cap_step = 1'b1;
               state_in     = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/galvo_position_ramp.sv */
// Galvo DAC setpoint ramp, one item at a time. From accept to result valid, a tick or
// ignored code passes the target, commit and output states; a move also loads the distance
// and, unless already there or speed is zero, runs three divides through one bit-serial divider.
// A new word is taken the cycle after the result is loaded; loading the result waits
// in the output state while a previous result waits on rsp_ready.
// Synchronous reset: registers to their reset values, ramp at code 0, jump mode.
module galvo_position_ramp import gpr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_command,
   input  logic signed [POS_W-1:0] req_position,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DAC_BITS-1:0]     rsp_dac_value,
   output logic [FRAME_W-1:0]      rsp_spi_frame,
   output logic                    rsp_at_target,
   output logic [DIR_W-1:0]        rsp_direction,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   gpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gpr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .req_command   (req_command),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dac_value (rsp_dac_value),
      .rsp_spi_frame (rsp_spi_frame),
      .rsp_at_target (rsp_at_target),
      .rsp_direction (rsp_direction)
   );

endmodule

/* rtl/gpr_chk.sv */
// Port-level checks on the galvo position ramp, attached by bind.
// Depends on gpr_pkg and the galvo_position_ramp top level.
module gpr_chk import gpr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [DAC_BITS-1:0] rsp_dac_value,
   input logic [FRAME_W-1:0]  rsp_spi_frame,
   input logic                rsp_at_target,
   input logic [DIR_W-1:0]    rsp_direction
);

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_ready && !rsp_valid)
      else $error("not idle after reset");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dac_value)
         && $stable(rsp_spi_frame) && $stable(rsp_at_target) && $stable(rsp_direction))
      else $error("stalled result changed");

endmodule

bind galvo_position_ramp gpr_chk u_gpr_chk (.*);

/* test/galvo_ramp_checker.sv */
// Checker for the galvo position ramp: tracks register writes, predicts each DAC word
// from the accepted request words and compares the result channel against it.
// Depends on gpr_pkg for widths, command, direction and register codes.
module galvo_ramp_checker import gpr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [CMD_W-1:0]        req_command,
   input  logic signed [POS_W-1:0] req_position,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [DAC_BITS-1:0]     rsp_dac_value,
   input  logic [FRAME_W-1:0]      rsp_spi_frame,
   input  logic                    rsp_at_target,
   input  logic [DIR_W-1:0]        rsp_direction,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic                    pready,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output int                      fail_count,
   output int                      pending
);

   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic [DAC_BITS-1:0] dac_value;
      logic [FRAME_W-1:0]  spi_frame;
      logic                at_target;
      logic [DIR_W-1:0]    direction;
   } dac_word_type;

   cfg_type             ramp_cfg;
   logic [DAC_BITS-1:0] cur_code;
   logic [DAC_BITS-1:0] tgt_code;
   logic [DIST_W-1:0]   step_code;
   logic [DIR_W-1:0]    ramp_dir;
   dac_word_type        dac_words_due[$];
   int                  errors = 0;
   int                  words_checked = 0;

   function automatic logic [DIST_W-1:0] ramp_step_size(input logic [DAC_BITS-1:0] from_code,
                                                       input logic [DAC_BITS-1:0] to_code);
      longint unsigned gap;
      longint unsigned span;
      longint unsigned dur;
      longint unsigned per;
      longint unsigned ticks;
      gap = (to_code > from_code) ? to_code - from_code : from_code - to_code;
      if (gap == 0 || ramp_cfg.speed == 0) return '0;
      span  = gap << FRACTION_BITS;
      dur   = span / ramp_cfg.speed;
      per   = (ramp_cfg.period == 0) ? 1 : ramp_cfg.period;
      ticks = dur / per;
      if (ticks == 0) ticks = 1;
      return DIST_W'(span / ticks);
   endfunction

   // advances the ramp state by one request word and returns the DAC word it yields
   function automatic dac_word_type apply_word(input logic [CMD_W-1:0] cmd,
                                               input logic signed [POS_W-1:0] pos);
      longint          sum;
      longint unsigned moved;
      dac_word_type    w;
      w.spi_frame = '0;
      case (cmd)
         CMD_ABS, CMD_REL: begin
            sum = longint'(pos) + ((cmd == CMD_ABS) ? longint'(ramp_cfg.center)
                                                    : longint'(cur_code));
            if (sum > longint'(ramp_cfg.dac_max)) sum = longint'(ramp_cfg.dac_max);
            else if (sum < longint'(ramp_cfg.dac_min)) sum = longint'(ramp_cfg.dac_min);
            if (sum < 0) sum = 0;
            if (sum > longint'(DAC_FULL)) sum = longint'(DAC_FULL);
            tgt_code = DAC_BITS'(sum);
            if (cur_code != tgt_code) begin
               ramp_dir  = (cur_code < tgt_code) ? DIR_INC : DIR_DEC;
               step_code = ramp_step_size(cur_code, tgt_code);
            end
         end
         CMD_TICK: begin
            case (ramp_dir)
               DIR_DEC: begin
                  // saturate at zero before clamping to the target
                  moved = (step_code >= cur_code) ? 0 : cur_code - step_code;
                  if (moved < tgt_code) moved = tgt_code;
               end
               DIR_INC: begin
                  moved = cur_code + step_code;
                  if (moved > tgt_code) moved = tgt_code;
               end
               DIR_JUMP: moved = tgt_code;
               default: moved = cur_code;
            endcase
            cur_code    = DAC_BITS'(moved);
            w.spi_frame = {ramp_cfg.write_code, cur_code, 2'b00};
         end
         default: ;
      endcase
      w.dac_value = cur_code;
      w.at_target = (cur_code == tgt_code);
      w.direction = ramp_dir;
      return w;
   endfunction

   always @(posedge clock) begin
      dac_word_type got;
      dac_word_type due;
      if (reset) begin
         ramp_cfg  = '{SPEED_RESET, PERIOD_RESET, CENTER_RESET, DMIN_RESET, DAC_FULL,
                       CODE_RESET};
         cur_code  = '0;
         tgt_code  = CENTER_RESET;
         step_code = '0;
         ramp_dir  = DIR_JUMP;
         dac_words_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_SPEED:  ramp_cfg.speed      = pwdata[CFG_W-1:0];
               REG_PERIOD: ramp_cfg.period     = pwdata[CFG_W-1:0];
               REG_CENTER: ramp_cfg.center     = pwdata[DAC_BITS-1:0];
               REG_MIN:    ramp_cfg.dac_min    = pwdata[DAC_BITS-1:0];
               REG_MAX:    ramp_cfg.dac_max    = pwdata[DAC_BITS-1:0];
               REG_CODE:   ramp_cfg.write_code = pwdata[CODE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_dac_value, rsp_spi_frame, rsp_at_target, rsp_direction};
            words_checked++;
            if (dac_words_due.size() == 0) begin
               errors++;
               if (errors <= MAX_SHOWN)
                  $display("word %0d unexpected: dac %h frame %h at_target %b dir %0d",
                           words_checked, got.dac_value, got.spi_frame, got.at_target,
                           got.direction);
            end else begin
               due = dac_words_due.pop_front();
               if (got !== due) begin
                  errors++;
                  if (errors <= MAX_SHOWN) begin
                     $write("word %0d mismatch: expected dac %h frame %h at_target %b dir %0d",
                            words_checked, due.dac_value, due.spi_frame, due.at_target,
                            due.direction);
                     $display(", got dac %h frame %h at_target %b dir %0d",
                              got.dac_value, got.spi_frame, got.at_target, got.direction);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            dac_words_due.push_back(apply_word(req_command, req_position));
      end
      pending    <= dac_words_due.size();
      fail_count <= errors;
   end

endmodule

/* test/tb_galvo_position_ramp.sv */
// Testbench top for galvo_position_ramp: clock, reset, register writes, request
// stimulus with bursts and gaps, result stalls, watchdog and verdict.
// Depends on gpr_pkg, galvo_position_ramp and galvo_ramp_checker.
module tb_galvo_position_ramp;
   import gpr_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int TAIL_CYCLES  = 100;
   localparam int RANDOM_WORDS = 800;
   localparam int PHASES       = 8;

   localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;
   localparam logic signed [POS_W-1:0] POS_MAX    = {1'b0, {DAC_BITS{1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN    = {1'b1, {DAC_BITS{1'b0}}};

   logic                    clock        = 1'b0;
   logic                    reset        = 1'b1;
   logic                    req_valid    = 1'b0;
   logic [CMD_W-1:0]        req_command  = CMD_TICK;
   logic signed [POS_W-1:0] req_position = '0;
   logic                    rsp_ready    = 1'b0;
   logic                    psel         = 1'b0;
   logic                    penable      = 1'b0;
   logic                    pwrite       = 1'b0;
   logic [ADDR_W-1:0]       paddr        = '0;
   logic [DATA_W-1:0]       pwdata       = '0;
   logic                    req_ready;
   logic                    rsp_valid;
   logic [DAC_BITS-1:0]     rsp_dac_value;
   logic [FRAME_W-1:0]      rsp_spi_frame;
   logic                    rsp_at_target;
   logic [DIR_W-1:0]        rsp_direction;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;
   int                      fail_count;
   int                      pending;

   int          burst_left  = 0;
   int          idle_cycles = 0;
   int          ready_phase = 0;
   int          stall_mode  = 0;
   int unsigned words_sent  = 0;

   galvo_position_ramp uut (.*);
   galvo_ramp_checker  u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (ready_phase == 0) stall_mode <= $urandom_range(0, 3);
      ready_phase <= (ready_phase + 1) % 64;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (ready_phase % 8 == 0);
         default: rsp_ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else if (idle_cycles == IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      if (cmd != CMD_UNUSED) words_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic set_config(input cfg_type c);
      csr_write(REG_SPEED, DATA_W'(c.speed));
      csr_write(REG_PERIOD, DATA_W'(c.period));
      csr_write(REG_CENTER, DATA_W'(c.center));
      csr_write(REG_MIN, DATA_W'(c.dac_min));
      csr_write(REG_MAX, DATA_W'(c.dac_max));
      csr_write(REG_CODE, DATA_W'(c.write_code));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cfg_type random_cfg();
      cfg_type             c;
      logic [DAC_BITS-1:0] a;
      logic [DAC_BITS-1:0] b;
      // small speed*period gives multi-tick ramps, large values jump in one tick
      case ($urandom_range(0, 3))
         0: c.speed = CFG_W'($urandom_range(1, 64));
         1: c.speed = CFG_W'($urandom());
         2: c.speed = '1;
         default: c.speed = CFG_W'($urandom_range(0, 1));
      endcase
      case ($urandom_range(0, 3))
         0: c.period = CFG_W'($urandom_range(1, 8));
         1: c.period = CFG_W'($urandom());
         2: c.period = '1;
         default: c.period = CFG_W'($urandom_range(0, 1));
      endcase
      case ($urandom_range(0, 5))
         0: c.center = '0;
         1: c.center = '1;
         default: c.center = DAC_BITS'($urandom());
      endcase
      a = DAC_BITS'($urandom());
      b = DAC_BITS'($urandom());
      case ($urandom_range(0, 3))
         0: begin
            c.dac_min = '0;
            c.dac_max = '1;
         end
         1: begin
            c.dac_min = (a < b) ? a : b;
            c.dac_max = (a < b) ? b : a;
         end
         2: begin
            c.dac_min = a;
            c.dac_max = b;
         end
         default: begin
            c.dac_min = a;
            c.dac_max = a + DAC_BITS'($urandom_range(0, 64));
         end
      endcase
      c.write_code = CODE_W'($urandom());
      return c;
   endfunction

   function automatic logic signed [POS_W-1:0] random_position();
      case ($urandom_range(0, 5))
         0, 1: return POS_W'($urandom());
         2, 3: return POS_W'($urandom_range(0, 4000)) - POS_W'(2000);
         4: return ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
         default: return POS_W'($urandom_range(0, 3)) - POS_W'(1);
      endcase
   endfunction

   initial begin
      int          phase;
      int unsigned phase_end;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: jump to center, ignored code, clamps at both ends, equal target
      send_word(CMD_TICK, '0);
      send_word(CMD_UNUSED, -19'sd1);
      send_word(CMD_ABS, POS_MAX);
      send_word(CMD_TICK, POS_MAX);
      send_word(CMD_TICK, POS_MIN);
      send_word(CMD_REL, '0);
      send_word(CMD_REL, POS_MIN);
      send_word(CMD_TICK, '0);
      send_word(CMD_ABS, '0);
      send_word(CMD_TICK, '0);

      // largest speed and period: single-tick moves, decrease saturating at zero
      wait_drained();
      set_config('{16'hFFFF, 16'hFFFF, DAC_FULL, DMIN_RESET, DAC_FULL, 4'hF});
      send_word(CMD_ABS, POS_MIN);
      send_word(CMD_TICK, '0);
      send_word(CMD_ABS, '0);
      send_word(CMD_TICK, '0);
      send_word(CMD_ABS, -19'sd262143);
      send_word(CMD_TICK, '0);
      send_word(CMD_REL, POS_MAX);
      send_word(CMD_TICK, '0);

      // zero speed and period, crossed limits
      wait_drained();
      set_config('{16'd0, 16'd0, 18'd0, 18'd200000, 18'd100000, 4'h0});
      send_word(CMD_ABS, POS_MAX);
      send_word(CMD_TICK, '0);
      send_word(CMD_ABS, POS_MIN);
      send_word(CMD_TICK, '0);

      // slowest ramp, one code per tick
      wait_drained();
      set_config('{16'd1, 16'd0, CENTER_RESET, DMIN_RESET, DAC_FULL, 4'h9});
      send_word(CMD_ABS, 19'sd5);
      send_word(CMD_TICK, '0);
      send_word(CMD_TICK, '0);

      words_sent = 0;
      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         set_config(random_cfg());
         phase_end = words_sent + RANDOM_WORDS / PHASES;
         while (words_sent < phase_end) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: begin
                  send_word(($urandom_range(0, 1) != 0) ? CMD_ABS : CMD_REL, random_position());
                  repeat ($urandom_range(1, 24)) send_word(CMD_TICK, POS_W'($urandom()));
               end
               7: repeat ($urandom_range(1, 8)) send_word(CMD_TICK, POS_W'($urandom()));
               8: send_word(CMD_UNUSED, POS_W'($urandom()));
               default: begin
                  send_word(CMD_ABS, random_position());
                  send_word(CMD_REL, random_position());
                  send_word(CMD_TICK, '0);
               end
            endcase
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
